// ===== rtl/ecd_pkg.sv =====
// ecd_pkg: shared types and codes for the nearest-car dispatch unit
// used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

    localparam int OP_W     = 2;
    localparam int CAR_IN_W = 4;
    localparam int FLOOR_W  = 6;
    localparam int DIR_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_CAR  = 2'd0,
        OP_HALL = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_CAR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_ENQ   = 3'd2,
        S_TREAD = 3'd3,
        S_TUPD  = 3'd4
    } state_t;

    typedef struct packed {
        logic load;
        logic load_named;
        logic scan_step;
        logic enq_fire;
        logic mem_rd;
        logic tick_fire;
    } cmd_t;

    typedef struct packed {
        logic last_car;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ecd_req_if.sv =====
// ecd_req_if: request channel with valid/ready handshake
// depends on ecd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ecd_req_if;
    logic                          valid;
    logic                          ready;
    logic [ecd_pkg::OP_W-1:0]      op;
    logic [ecd_pkg::CAR_IN_W-1:0]  car;
    logic [ecd_pkg::FLOOR_W-1:0]   target_floor;

    modport source (output valid, output op, output car, output target_floor, input ready);
    modport sink   (input valid, input op, input car, input target_floor, output ready);
endinterface

`default_nettype wire

// ===== rtl/ecd_rsp_if.sv =====
// ecd_rsp_if: result channel with valid/ready handshake
// depends on ecd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ecd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ecd_pkg::CAR_IN_W-1:0]  car_index;
    logic [ecd_pkg::FLOOR_W-1:0]   car_floor;
    logic [ecd_pkg::DIR_W-1:0]     direction;
    logic [ecd_pkg::STATUS_W-1:0]  status;
    logic                          last;

    modport source (output valid, output car_index, output car_floor, output direction,
                    output status, output last, input ready);
    modport sink   (input valid, input car_index, input car_floor, input direction,
                    input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ecd_ctrl.sv =====
// ecd_ctrl: sequencing state machine of the dispatch unit
// depends on ecd_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module ecd_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [ecd_pkg::OP_W-1:0]  in_op,
    input  ecd_pkg::sts_t                  sts,
    output logic                           in_ready,
    output ecd_pkg::cmd_t                  cmd
);

    ecd_pkg::state_t state_reg;
    ecd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ecd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.load_named = (in_op == ecd_pkg::OP_CAR);
                    unique case (in_op)
                        ecd_pkg::OP_CAR:  state_next = ecd_pkg::S_ENQ;
                        ecd_pkg::OP_HALL: state_next = ecd_pkg::S_SCAN;
                        ecd_pkg::OP_TICK: state_next = ecd_pkg::S_TREAD;
                        default:          state_next = ecd_pkg::S_IDLE;
                    endcase
                end
            end
            ecd_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.last_car)
                begin
                    state_next = ecd_pkg::S_ENQ;
                end
            end
            ecd_pkg::S_ENQ:
            begin
                if (sts.out_free)
                begin
                    cmd.enq_fire = 1'b1;
                    state_next   = ecd_pkg::S_IDLE;
                end
            end
            ecd_pkg::S_TREAD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ecd_pkg::S_TUPD;
            end
            ecd_pkg::S_TUPD:
            begin
                if (sts.out_free)
                begin
                    cmd.tick_fire = 1'b1;
                    state_next    = sts.last_car ? ecd_pkg::S_IDLE : ecd_pkg::S_TREAD;
                end
            end
            default:
            begin
                state_next = ecd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ecd_datapath.sv =====
// ecd_datapath: car state, target queue memory, nearest-car search and result register
// depends on ecd_pkg and drives the result channel through ecd_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module ecd_datapath #(
    parameter int NUM_CARS    = 4,
    parameter int QUEUE_DEPTH = 8,
    parameter int FLOOR_COUNT = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  ecd_pkg::cmd_t                      cmd,
    input  wire logic [ecd_pkg::CAR_IN_W-1:0]  in_car,
    input  wire logic [ecd_pkg::FLOOR_W-1:0]   in_floor,
    output ecd_pkg::sts_t                      sts,
    ecd_rsp_if.source                          rsp
);

    localparam int CAR_W  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int FLR_W  = ($clog2(FLOOR_COUNT) < ecd_pkg::FLOOR_W) ?
                            $clog2(FLOOR_COUNT) : ecd_pkg::FLOOR_W;
    localparam int DEPTH  = NUM_CARS * QUEUE_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // per-car state
    logic [FLR_W-1:0]  floor_reg [NUM_CARS];
    ecd_pkg::dir_t     dir_reg   [NUM_CARS];
    logic [QPTR_W-1:0] head_reg  [NUM_CARS];
    logic [CNT_W-1:0]  count_reg [NUM_CARS];

    // target queue memory
    logic [FLR_W-1:0]  mem [DEPTH];
    logic [FLR_W-1:0]  rd_data_reg;

    // request context
    logic [CAR_W-1:0]              idx_reg;
    logic [CAR_W-1:0]              idx_next;
    logic [CAR_W-1:0]              best_reg;
    logic [CAR_W-1:0]              best_next;
    logic [FLR_W:0]                bestd_reg;
    logic [FLR_W:0]                bestd_next;
    logic [FLR_W-1:0]              flr_reg;
    logic [ecd_pkg::CAR_IN_W-1:0]  car_reg;
    logic                          bad_reg;

    // result register
    logic                          rsp_valid_reg;
    logic [ecd_pkg::CAR_IN_W-1:0]  res_car_reg;
    logic [ecd_pkg::FLOOR_W-1:0]   res_floor_reg;
    ecd_pkg::dir_t                 res_dir_reg;
    ecd_pkg::status_t              res_status_reg;
    logic                          res_last_reg;

    logic [FLR_W-1:0]  flr_in;
    logic [FLR_W-1:0]  cur_floor;
    ecd_pkg::dir_t     cur_dir;
    logic [QPTR_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [FLR_W-1:0]  car_gap;
    logic              full;
    logic [CNT_W:0]    slot_sum;
    logic [QPTR_W-1:0] slot;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              do_enq;
    logic [FLR_W-1:0]  nf;
    ecd_pkg::dir_t     nd;
    logic [QPTR_W-1:0] nh;
    logic [CNT_W-1:0]  nc;
    logic              emit;

    assign cur_floor = floor_reg[idx_reg];
    assign cur_dir   = dir_reg[idx_reg];
    assign cur_head  = head_reg[idx_reg];
    assign cur_count = count_reg[idx_reg];

    assign flr_in = (32'(in_floor) > FLOOR_COUNT - 1) ? FLR_W'(FLOOR_COUNT - 1)
                                                       : FLR_W'(in_floor);

    assign car_gap = (cur_floor > flr_reg) ? FLR_W'(cur_floor - flr_reg)
                                           : FLR_W'(flr_reg - cur_floor);

    assign full     = (cur_count == CNT_W'(QUEUE_DEPTH));
    assign slot_sum = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_count);
    assign slot     = (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                      QPTR_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : QPTR_W'(slot_sum);
    assign wr_addr  = AW'(32'(idx_reg) * QUEUE_DEPTH + 32'(slot));
    assign rd_addr  = AW'(32'(idx_reg) * QUEUE_DEPTH + 32'(cur_head));
    assign do_enq   = cmd.enq_fire && !bad_reg && !full;
    assign emit     = cmd.enq_fire || cmd.tick_fire;

    assign sts = '{last_car: (idx_reg == CAR_W'(NUM_CARS - 1)),
                   out_free: (!rsp_valid_reg || rsp.ready)};

    // nearest-car search, one car per cycle
    always_comb
    begin
        best_next  = best_reg;
        bestd_next = bestd_reg;
        if ({1'b0, car_gap} < bestd_reg)
        begin
            best_next  = idx_reg;
            bestd_next = {1'b0, car_gap};
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = (cmd.load_named && (32'(in_car) < NUM_CARS)) ? CAR_W'(in_car) : '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = sts.last_car ? best_next : CAR_W'(idx_reg + 1'b1);
        end
        else if (cmd.tick_fire)
        begin
            idx_next = CAR_W'(idx_reg + 1'b1);
        end
    end

    // tick step for the selected car
    always_comb
    begin
        nf = cur_floor;
        nd = ecd_pkg::DIR_IDLE;
        nh = cur_head;
        nc = cur_count;
        if (cur_count != '0)
        begin
            nh = (cur_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(cur_head + 1'b1);
            nc = CNT_W'(cur_count - 1'b1);
            nf = rd_data_reg;
            if (cur_floor < rd_data_reg)
            begin
                nd = ecd_pkg::DIR_UP;
            end
            else if (cur_floor > rd_data_reg)
            begin
                nd = ecd_pkg::DIR_DOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CARS; i++)
            begin
                floor_reg[i] <= '0;
                dir_reg[i]   <= ecd_pkg::DIR_IDLE;
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            idx_reg       <= '0;
            best_reg      <= '0;
            bestd_reg     <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                best_reg  <= '0;
                bestd_reg <= '1;
            end
            else if (cmd.scan_step)
            begin
                best_reg  <= best_next;
                bestd_reg <= bestd_next;
            end
            if (do_enq)
            begin
                count_reg[idx_reg] <= CNT_W'(cur_count + 1'b1);
            end
            if (cmd.tick_fire)
            begin
                floor_reg[idx_reg] <= nf;
                dir_reg[idx_reg]   <= nd;
                head_reg[idx_reg]  <= nh;
                count_reg[idx_reg] <= nc;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload and memory, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            flr_reg <= flr_in;
            car_reg <= in_car;
            bad_reg <= cmd.load_named && (32'(in_car) >= NUM_CARS);
        end
        if (do_enq)
        begin
            mem[wr_addr] <= flr_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.tick_fire)
        begin
            res_car_reg    <= ecd_pkg::CAR_IN_W'(idx_reg);
            res_floor_reg  <= ecd_pkg::FLOOR_W'(nf);
            res_dir_reg    <= nd;
            res_status_reg <= ecd_pkg::ST_OK;
            res_last_reg   <= sts.last_car;
        end
        else if (cmd.enq_fire)
        begin
            res_last_reg <= 1'b1;
            if (bad_reg)
            begin
                res_car_reg    <= car_reg;
                res_floor_reg  <= '0;
                res_dir_reg    <= ecd_pkg::DIR_IDLE;
                res_status_reg <= ecd_pkg::ST_BAD_CAR;
            end
            else
            begin
                res_car_reg    <= ecd_pkg::CAR_IN_W'(idx_reg);
                res_floor_reg  <= ecd_pkg::FLOOR_W'(cur_floor);
                res_dir_reg    <= cur_dir;
                res_status_reg <= full ? ecd_pkg::ST_FULL : ecd_pkg::ST_OK;
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.car_index = res_car_reg;
    assign rsp.car_floor = res_floor_reg;
    assign rsp.direction = res_dir_reg;
    assign rsp.status    = res_status_reg;
    assign rsp.last      = res_last_reg;

endmodule

`default_nettype wire

// ===== rtl/elevator_nearest_car_dispatch_unit.sv =====
// elevator_nearest_car_dispatch_unit: top level of the nearest-car dispatch unit
// instantiates ecd_ctrl and ecd_datapath, channels are ecd_req_if and ecd_rsp_if
//
// usage: requests arrive on req (op, car, target_floor) with a valid/ready transfer.
// op 0 queues a floor on the named car, op 1 queues it on the nearest car (lowest index
// on a tie), op 2 advances every car by one target and reports all cars in index order.
// results leave on rsp; the final result of a request has last set.
// steps: a named-car request is loaded and then enqueued, a hall request is loaded,
// scanned (one distance compare per car) and enqueued, a tick is loaded and then does one
// target memory read and one update per car. the next request is taken once the previous
// one is finished, one at a time.
// the result sits in an output register: a new request is taken while it waits, and a
// stalled receiver holds the unit at the next result until rsp.ready returns.
// reset: all cars at floor zero, idle, queues empty; the target memory is not cleared
// and needs no clearing pass, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module elevator_nearest_car_dispatch_unit #(
    parameter int NUM_CARS    = 4,
    parameter int QUEUE_DEPTH = 8,
    parameter int FLOOR_COUNT = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ecd_req_if.sink    req,
    ecd_rsp_if.source  rsp
);

    ecd_pkg::cmd_t cmd;
    ecd_pkg::sts_t sts;
    logic          in_ready;

    assign req.ready = in_ready;

    ecd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    ecd_datapath #(
        .NUM_CARS    (NUM_CARS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_car   (req.car),
        .in_floor (req.target_floor),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
